/* hdl/lei_pkg.sv */
`timescale 1ns / 1ps

package lei_pkg;

  // Coordinate, product and derivative widths
  localparam int CoordW  = 32;
  localparam int MulAW   = 33;
  localparam int MulBW   = 32;
  localparam int ProdW   = 64;
  localparam int DerivW  = 43;
  localparam int AccW    = 42;
  localparam int DtFracW = 24;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [MulAW-1:0]  mul_a_t;
  typedef logic signed [MulBW-1:0]  mul_b_t;
  typedef logic signed [ProdW-1:0]  prod_t;

  localparam coord_t OneQ22 = 32'sd4194304;

  localparam prod_t SatMax = 64'sd2147483647;
  localparam prod_t SatMin = -64'sd2147483648;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    RegSigma    = 3'd0,
    RegRho      = 3'd1,
    RegBeta     = 3'd2,
    RegTimeStep = 3'd3,
    RegZoom     = 3'd4
  } reg_idx_e;

  // Clamp a wide signed value to the coordinate range
  function automatic coord_t sat_coord(input prod_t v);
    coord_t r;
    if (v > SatMax) begin
      r = coord_t'(SatMax);
    end else if (v < SatMin) begin
      r = coord_t'(SatMin);
    end else begin
      r = coord_t'(v);
    end
    return r;
  endfunction

endpackage

/* hdl/lei_mul.sv */
`timescale 1ns / 1ps

// Shared signed multiplier with a registered product
module lei_mul (
  input  logic            clk_i,
  input  logic            en_i,
  input  lei_pkg::mul_a_t a_i,
  input  lei_pkg::mul_b_t b_i,
  output lei_pkg::prod_t  prod_o
);

  logic signed [lei_pkg::MulAW+lei_pkg::MulBW-1:0] full;
  lei_pkg::prod_t                                  prod_q;

  assign full = a_i * b_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= $signed(full[lei_pkg::ProdW-1:0]);
    end
  end

  assign prod_o = prod_q;

endmodule

/* hdl/lorenz_euler_integrator.sv */
`timescale 1ns / 1ps

// Channel    Dir  Handshake                     Payload
// s_axis     in   s_axis_tvalid/s_axis_tready   tdata[0] restart
// m_axis     out  m_axis_tvalid/m_axis_tready   tdata pos_x, pos_y, pos_z
// cfg        in   cfg_we_i (no wait)            cfg_idx_i, cfg_data_i
//
// A step word and a restart word both go from acceptance to the result
// register through the single shared multiplier, which runs one product per
// cycle through a fixed schedule of 14 (step) or 3 (restart) products. The
// input is taken only while the sequencer is idle. Reset loads the default
// registers and the point (1,1,1). The result register holds a finished
// word while the next one is computed; the sequencer waits on its last step
// when the result register is still full.
module lorenz_euler_integrator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [21:0] cfg_data_i
);

  // Schedule: the step value names the product issued in that cycle; the
  // product issued one step earlier is consumed at the same time.
  localparam logic [3:0] StepSigma = 4'd0;
  localparam logic [3:0] StepRho   = 4'd1;
  localparam logic [3:0] StepXz    = 4'd2;
  localparam logic [3:0] StepXy    = 4'd3;
  localparam logic [3:0] StepBeta  = 4'd4;
  localparam logic [3:0] StepDlx   = 4'd5;
  localparam logic [3:0] StepDhx   = 4'd6;
  localparam logic [3:0] StepDly   = 4'd7;
  localparam logic [3:0] StepDhy   = 4'd8;
  localparam logic [3:0] StepDlz   = 4'd9;
  localparam logic [3:0] StepDhz   = 4'd10;
  localparam logic [3:0] StepZoomX = 4'd11;
  localparam logic [3:0] StepZoomY = 4'd12;
  localparam logic [3:0] StepZoomZ = 4'd13;
  localparam logic [3:0] StepOut   = 4'd14;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } state_e;

  state_e state_q;
  logic [3:0] step_q;
  logic       restart_q;

  // configuration registers
  logic [20:0] sigma_q;
  logic [21:0] rho_q;
  logic [17:0] beta_q;
  logic [20:0] dt_q;
  logic [11:0] zoom_q;

  // point and intermediates
  lei_pkg::coord_t x_q, y_q, z_q;
  lei_pkg::coord_t zx_q, zy_q;
  logic signed [lei_pkg::DerivW-1:0] dx_q, dy_q, dz_q;
  logic signed [lei_pkg::AccW-1:0]   acc_q;

  logic        out_valid_q;
  logic [95:0] out_q;

  lei_pkg::mul_a_t mul_a;
  lei_pkg::mul_b_t mul_b;
  lei_pkg::prod_t  prod;
  logic            mul_en;
  logic            stall;
  logic            in_acc;
  logic            out_load;
  lei_pkg::coord_t zoom_sat;

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // hold the last step while the previous result is still waiting
  assign stall    = (step_q == StepOut) && out_valid_q && !m_axis_tready;
  assign mul_en   = (state_q == StRun) && (step_q != StepOut);
  assign out_load = (state_q == StRun) && (step_q == StepOut) && !stall;

  assign zoom_sat = lei_pkg::sat_coord(prod >>> 8);

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_q)
      StepSigma: begin
        mul_a = lei_pkg::MulAW'(y_q) - lei_pkg::MulAW'(x_q);
        mul_b = lei_pkg::mul_b_t'({11'b0, sigma_q});
      end
      StepRho: begin
        mul_a = lei_pkg::MulAW'(x_q);
        mul_b = lei_pkg::mul_b_t'({10'b0, rho_q});
      end
      StepXz: begin
        mul_a = lei_pkg::MulAW'(x_q);
        mul_b = z_q;
      end
      StepXy: begin
        mul_a = lei_pkg::MulAW'(x_q);
        mul_b = y_q;
      end
      StepBeta: begin
        mul_a = lei_pkg::MulAW'(z_q);
        mul_b = lei_pkg::mul_b_t'({14'b0, beta_q});
      end
      StepDlx: begin
        mul_a = lei_pkg::mul_a_t'({9'b0, dx_q[lei_pkg::DtFracW-1:0]});
        mul_b = lei_pkg::mul_b_t'({11'b0, dt_q});
      end
      StepDhx: begin
        mul_a = lei_pkg::MulAW'(dx_q >>> lei_pkg::DtFracW);
        mul_b = lei_pkg::mul_b_t'({11'b0, dt_q});
      end
      StepDly: begin
        mul_a = lei_pkg::mul_a_t'({9'b0, dy_q[lei_pkg::DtFracW-1:0]});
        mul_b = lei_pkg::mul_b_t'({11'b0, dt_q});
      end
      StepDhy: begin
        mul_a = lei_pkg::MulAW'(dy_q >>> lei_pkg::DtFracW);
        mul_b = lei_pkg::mul_b_t'({11'b0, dt_q});
      end
      StepDlz: begin
        mul_a = lei_pkg::mul_a_t'({9'b0, dz_q[lei_pkg::DtFracW-1:0]});
        mul_b = lei_pkg::mul_b_t'({11'b0, dt_q});
      end
      StepDhz: begin
        mul_a = lei_pkg::MulAW'(dz_q >>> lei_pkg::DtFracW);
        mul_b = lei_pkg::mul_b_t'({11'b0, dt_q});
      end
      StepZoomX: begin
        mul_a = lei_pkg::MulAW'(x_q);
        mul_b = lei_pkg::mul_b_t'({20'b0, zoom_q});
      end
      StepZoomY: begin
        mul_a = lei_pkg::MulAW'(y_q);
        mul_b = lei_pkg::mul_b_t'({20'b0, zoom_q});
      end
      StepZoomZ: begin
        mul_a = lei_pkg::MulAW'(z_q);
        mul_b = lei_pkg::mul_b_t'({20'b0, zoom_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  lei_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Sequencer and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= StepSigma;
      restart_q   <= 1'b0;
      out_valid_q <= 1'b0;
      sigma_q     <= 21'd655360;
      rho_q       <= 22'd1835008;
      beta_q      <= 18'd174762;
      dt_q        <= 21'd167772;
      zoom_q      <= 12'd1280;
      x_q         <= lei_pkg::OneQ22;
      y_q         <= lei_pkg::OneQ22;
      z_q         <= lei_pkg::OneQ22;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        unique case (lei_pkg::reg_idx_e'(cfg_idx_i))
          lei_pkg::RegSigma:    sigma_q <= cfg_data_i[20:0];
          lei_pkg::RegRho:      rho_q   <= cfg_data_i;
          lei_pkg::RegBeta:     beta_q  <= cfg_data_i[17:0];
          lei_pkg::RegTimeStep: dt_q    <= cfg_data_i[20:0];
          lei_pkg::RegZoom:     zoom_q  <= cfg_data_i[11:0];
          default: ;  // drop writes to unknown indexes
        endcase
      end

      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            state_q   <= StRun;
            restart_q <= s_axis_tdata[0];
            if (s_axis_tdata[0]) begin
              // reload the start point and go straight to the zoom products
              x_q    <= lei_pkg::OneQ22;
              y_q    <= lei_pkg::OneQ22;
              z_q    <= lei_pkg::OneQ22;
              step_q <= StepZoomX;
            end else begin
              step_q <= StepSigma;
            end
          end
        end
        StRun: begin
          if (!stall) begin
            // apply the new coordinates once their delta is complete
            if (step_q == StepDhy) begin
              x_q <= lei_pkg::sat_coord(lei_pkg::ProdW'(x_q) + lei_pkg::ProdW'(acc_q));
            end
            if (step_q == StepDhz) begin
              y_q <= lei_pkg::sat_coord(lei_pkg::ProdW'(y_q) + lei_pkg::ProdW'(acc_q));
            end
            if (step_q == StepZoomY && !restart_q) begin
              z_q <= lei_pkg::sat_coord(lei_pkg::ProdW'(z_q) + lei_pkg::ProdW'(acc_q));
            end
            if (step_q == StepOut) begin
              state_q <= StIdle;
              out_q   <= {zoom_sat, zy_q, zx_q};
            end else begin
              step_q <= step_q + 4'd1;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Datapath: consume the product issued one step earlier
  always_ff @(posedge clk_i) begin
    if (state_q == StRun && !stall) begin
      unique case (step_q)
        StepRho:   dx_q  <= lei_pkg::DerivW'(prod >>> 16);
        StepXz:    dy_q  <= lei_pkg::DerivW'(prod >>> 16) - lei_pkg::DerivW'(y_q);
        StepXy:    dy_q  <= dy_q - lei_pkg::DerivW'(prod >>> 22);
        StepBeta:  dz_q  <= lei_pkg::DerivW'(prod >>> 22);
        StepDlx:   dz_q  <= dz_q - lei_pkg::DerivW'(prod >>> 16);
        StepDhx:   acc_q <= lei_pkg::AccW'(prod >>> lei_pkg::DtFracW);
        StepDly:   acc_q <= acc_q + lei_pkg::AccW'(prod);
        StepDhy:   acc_q <= lei_pkg::AccW'(prod >>> lei_pkg::DtFracW);
        StepDlz:   acc_q <= acc_q + lei_pkg::AccW'(prod);
        StepDhz:   acc_q <= lei_pkg::AccW'(prod >>> lei_pkg::DtFracW);
        StepZoomX: acc_q <= acc_q + lei_pkg::AccW'(prod);
        StepZoomY: zx_q  <= zoom_sat;
        StepZoomZ: zy_q  <= zoom_sat;
        default: ;  // first issue and output load consume nothing here
      endcase
    end
  end

endmodule

/* test/lorenz_euler_integrator_tb.sv */
`timescale 1ns / 1ps

module lorenz_euler_integrator_tb;

  // Upper bound on the whole run, far above the slowest legal schedule.
  localparam int CycleLimit = 400000;
  // Cycles to let pass after the last result before touching registers.
  localparam int SettleCycles = 20;

  typedef struct {
    lei_pkg::coord_t x;
    lei_pkg::coord_t y;
    lei_pkg::coord_t z;
  } point_t;

  // Tracks the Lorenz point and the register file, and holds the zoomed
  // points that the block still owes us, oldest first.
  class lorenz_point_tracker;
    longint sigma, rho, beta, dt, zoom;
    lei_pkg::coord_t px, py, pz;
    point_t owed[$];
    int errors, steps, restarts, words, clipped;

    function new();
      sigma = 655360;
      rho   = 1835008;
      beta  = 174762;
      dt    = 167772;
      zoom  = 1280;
      px = lei_pkg::OneQ22;
      py = lei_pkg::OneQ22;
      pz = lei_pkg::OneQ22;
    endfunction

    function void write_reg(logic [2:0] idx, logic [21:0] val);
      case (idx)
        lei_pkg::RegSigma:    sigma = longint'(val[20:0]);
        lei_pkg::RegRho:      rho   = longint'(val);
        lei_pkg::RegBeta:     beta  = longint'(val[17:0]);
        lei_pkg::RegTimeStep: dt    = longint'(val[20:0]);
        lei_pkg::RegZoom:     zoom  = longint'(val[11:0]);
        default: ;
      endcase
    endfunction

    function lei_pkg::coord_t clamp(longint v);
      if (v > 64'sd2147483647) begin
        return lei_pkg::coord_t'(32'h7fffffff);
      end else if (v < -64'sd2147483648) begin
        return lei_pkg::coord_t'(32'h80000000);
      end
      return lei_pkg::coord_t'(v);
    endfunction

    function lei_pkg::coord_t scaled(lei_pkg::coord_t p);
      longint v;
      v = (longint'(p) * zoom) >>> 8;
      if (v > 64'sd2147483647 || v < -64'sd2147483648) clipped++;
      return clamp(v);
    endfunction

    // One accepted input word: reload the start point or take an Euler step
    function void take_tick(bit restart);
      longint x, y, z, dx, dy, dz;
      point_t want;
      if (restart) begin
        px = lei_pkg::OneQ22;
        py = lei_pkg::OneQ22;
        pz = lei_pkg::OneQ22;
        restarts++;
      end else begin
        x = longint'(px);
        y = longint'(py);
        z = longint'(pz);
        // all three derivatives come from the old point
        dx = (sigma * (y - x)) >>> 16;
        dy = ((rho * x) >>> 16) - y - ((x * z) >>> 22);
        dz = ((x * y) >>> 22) - ((beta * z) >>> 16);
        px = clamp(x + ((dx * dt) >>> 24));
        py = clamp(y + ((dy * dt) >>> 24));
        pz = clamp(z + ((dz * dt) >>> 24));
        steps++;
      end
      want.x = scaled(px);
      want.y = scaled(py);
      want.z = scaled(pz);
      owed.push_back(want);
    endfunction

    function int pending();
      return owed.size();
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("[%0t] mismatch on word %0d, %s: got %h, want %h",
               $realtime, words, what, got, want);
    endtask

    task check_word(logic [95:0] data);
      point_t want;
      if (owed.size() == 0) begin
        report("result with nothing owed", data[31:0], 32'h0);
      end else begin
        want = owed.pop_front();
        if (data[31:0]  !== want.x) report("pos_x", data[31:0],  want.x);
        if (data[63:32] !== want.y) report("pos_y", data[63:32], want.y);
        if (data[95:64] !== want.z) report("pos_z", data[95:64], want.z);
      end
      words++;
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [0] restart, [7:1] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;           // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = 3'd0;
  logic [21:0] cfg_data_i = 22'd0;

  lorenz_point_tracker tracker = new();

  // Stall rate of each side: a burst starts with odds 1 in N, 0 turns it off
  int tx_rate = 0;
  int rx_rate = 0;
  int rx_hold = 0;
  int settings_seen = 1;

  lorenz_euler_integrator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver: hold tready low in bursts of random length
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else if (rx_rate != 0 && $urandom_range(1, rx_rate) == 1) begin
      rx_hold = $urandom_range(0, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare every accepted output word against the oldest owed point
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_word(m_axis_tdata);
    end
  end

  // Watchdog: a hung handshake ends the run here
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d words still owed",
             CycleLimit, tracker.pending());
    $display("== FAIL ==");
    $finish;
  end

  // Present one word and hold it until the block takes it. Leaves tvalid
  // high so a back-to-back word needs no second assignment in one step.
  task automatic send_word(bit restart);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, restart};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.take_tick(restart);
  endtask

  task automatic feed(int n, bit restart);
    for (int i = 0; i < n; i++) send_word(restart);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop tvalid beforehand; wait until every owed word is back, then settle
  task automatic drain();
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [21:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    tracker.write_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly in-range values, with the range ends and full-width junk mixed in
  function automatic logic [21:0] pick(int lo, int hi, int width);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 22'(lo);
    if (r == 1) return 22'(hi);
    if (r == 2) return 22'($urandom & ((1 << width) - 1));
    return 22'($urandom_range(lo, hi));
  endfunction

  task automatic new_setting();
    drain();
    write_cfg(lei_pkg::RegSigma,    pick(0, 1310720, 21));
    write_cfg(lei_pkg::RegRho,      pick(0, 3276800, 22));
    write_cfg(lei_pkg::RegBeta,     pick(131072, 196608, 18));
    write_cfg(lei_pkg::RegTimeStep, pick(1, 1677722, 21));
    write_cfg(lei_pkg::RegZoom,     pick(0, 4095, 12));
    // unused indexes must leave the register file alone
    if ($urandom_range(0, 2) == 0) begin
      write_cfg(3'(int'(lei_pkg::RegZoom) + $urandom_range(1, 3)), 22'($urandom));
    end
    settings_seen++;
  endtask

  // Random words: mostly steps, now and then a restart to pull the point
  // back from saturation. Once per phase the sender may wait for the block
  // to empty completely.
  task automatic run_random(int n, bit stalls);
    int mid;
    bit hold_mid;
    mid = $urandom_range(n / 4, (3 * n) / 4);
    hold_mid = ($urandom_range(0, 1) == 1);
    tx_rate = stalls ? $urandom_range(0, 3) * 4 : 0;
    rx_rate = stalls ? $urandom_range(0, 3) * 4 : 0;
    for (int i = 0; i < n; i++) begin
      send_word($urandom_range(0, 24) == 0);
      if (i == mid && hold_mid) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (tracker.pending() != 0) @(posedge clk_i);
      end else if (tx_rate != 0 && $urandom_range(1, tx_rate) == 1) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: default setting, first step from reset point, restarts
    rx_rate = 6;
    feed(1, 1'b0);
    feed(2, 1'b1);
    feed(3, 1'b0);

    // Zero step size: the point must not move
    drain();
    write_cfg(lei_pkg::RegTimeStep, 22'd0);
    feed(2, 1'b0);

    // Zoom at both ends of its range
    drain();
    write_cfg(lei_pkg::RegTimeStep, 22'd167772);
    write_cfg(lei_pkg::RegZoom, 22'd0);
    feed(1, 1'b0);
    drain();
    write_cfg(lei_pkg::RegZoom, 22'd4095);
    feed(1, 1'b1);
    feed(1, 1'b0);

    // Writes to unused indexes are ignored
    drain();
    for (int k = int'(lei_pkg::RegZoom) + 1; k < 8; k++) write_cfg(3'(k), 22'h3fffff);
    feed(1, 1'b0);

    // Every register at full width: the point blows up and saturates
    drain();
    write_cfg(lei_pkg::RegSigma,    22'h1fffff);
    write_cfg(lei_pkg::RegRho,      22'h3fffff);
    write_cfg(lei_pkg::RegBeta,     22'h3ffff);
    write_cfg(lei_pkg::RegTimeStep, 22'h1fffff);
    feed(8, 1'b0);
    feed(1, 1'b1);

    // Lowest corner of the sigma, rho, beta and time-step ranges
    drain();
    write_cfg(lei_pkg::RegSigma,    22'd0);
    write_cfg(lei_pkg::RegRho,      22'd0);
    write_cfg(lei_pkg::RegBeta,     22'd131072);
    write_cfg(lei_pkg::RegTimeStep, 22'd1);
    feed(3, 1'b0);
    settings_seen += 6;

    // Random phases with stalls on both sides, back to the defaults once
    drain();
    write_cfg(lei_pkg::RegSigma,    22'd655360);
    write_cfg(lei_pkg::RegRho,      22'd1835008);
    write_cfg(lei_pkg::RegBeta,     22'd174762);
    write_cfg(lei_pkg::RegTimeStep, 22'd167772);
    write_cfg(lei_pkg::RegZoom,     22'd1280);
    settings_seen++;
    run_random(170, 1'b1);
    for (int p = 0; p < 5; p++) begin
      new_setting();
      run_random(170, 1'b1);
    end

    // Last stretch without random stalls on either side; the sender may still wait once for the block to empty
    new_setting();
    rx_rate = 0;
    run_random(170, 1'b0);

    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("covered %0d Euler steps and %0d restarts over %0d register settings,",
             tracker.steps, tracker.restarts, settings_seen);
    $display("%0d output words checked, %0d clipped coordinates, %0d mismatches",
             tracker.words, tracker.clipped, tracker.errors);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
